@@ src/tdpid_pkg.sv @@
// ============================================================================
// tdpid_pkg
// Shared types and constants for the trapezoid profile / dual PID block.
// ============================================================================
package tdpid_pkg;

    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int DRIVE_W     = 16;
    localparam int FRAC_SHIFT  = 24;
    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_PTR_W  = 3;
    localparam int FIFO_CNT_W  = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACCEL_PER_TICK = 3'd0,
        CFG_ACCEL_TICKS    = 3'd1,
        CFG_CRUISE_TICKS   = 3'd2,
        CFG_DECEL_TICKS    = 3'd3,
        CFG_DIRECTION      = 3'd4,
        CFG_GAIN_P         = 3'd5,
        CFG_GAIN_I         = 3'd6,
        CFG_GAIN_D         = 3'd7
    } cfg_index_t;

    // direction codes: 0 hold, 1 forward, anything with bit 1 set is reverse
    localparam logic [1:0] DIR_HOLD = 2'b00;

    localparam logic [CFG_W-1:0] GAIN_P_RESET = 16'd1024;
    localparam logic [CFG_W-1:0] GAIN_I_RESET = 16'd655;

    typedef struct packed {
        logic [CFG_W-1:0] accel_per_tick;
        logic [CFG_W-1:0] accel_ticks;
        logic [CFG_W-1:0] cruise_ticks;
        logic [CFG_W-1:0] decel_ticks;
        logic [1:0]       direction;
    } profile_cfg_t;

    typedef struct packed {
        logic [CFG_W-1:0] gain_p;
        logic [CFG_W-1:0] gain_i;
        logic [CFG_W-1:0] gain_d;
    } gains_t;

    // control that rides along with a word through the pipeline
    typedef struct packed {
        logic valid;
        logic start;
        logic done;
    } stage_ctl_t;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive_left;
        logic signed [DRIVE_W-1:0] drive_right;
        logic                      motion_done;
    } result_t;

endpackage

@@ src/tdpid_if.sv @@
// ============================================================================
// tdpid_tick_if / tdpid_drive_if
// Valid/ready channels for tick words in and drive words out.
// ============================================================================
interface tdpid_tick_if #(parameter int VEL_WIDTH = 24);
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic signed [VEL_WIDTH-1:0] enc_left;
    logic signed [VEL_WIDTH-1:0] enc_right;
    logic signed [VEL_WIDTH-1:0] enc_center;

    modport source (output valid, kind, enc_left, enc_right, enc_center, input ready);
    modport sink   (input valid, kind, enc_left, enc_right, enc_center, output ready);
endinterface

interface tdpid_drive_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] drive_left;
    logic signed [15:0] drive_right;
    logic               motion_done;

    modport source (output valid, drive_left, drive_right, motion_done, input ready);
    modport sink   (input valid, drive_left, drive_right, motion_done, output ready);
endinterface

@@ src/tdpid_profile.sv @@
// ============================================================================
// tdpid_profile
// Trapezoid profile state, target selection and per-wheel error (2 stages).
// ============================================================================
module tdpid_profile #(
    parameter int VEL_WIDTH  = 24,
    parameter int TICK_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic                          start,
    input  logic signed [VEL_WIDTH-1:0]   enc_left,
    input  logic signed [VEL_WIDTH-1:0]   enc_right,
    input  logic signed [VEL_WIDTH-1:0]   enc_center,
    input  tdpid_pkg::profile_cfg_t       cfg,
    output tdpid_pkg::stage_ctl_t         ctl,
    output logic signed [VEL_WIDTH:0]     err_left,
    output logic signed [VEL_WIDTH:0]     err_right
);
    import tdpid_pkg::*;

    localparam logic signed [32:0] ONE_S   = 33'sd1;
    localparam logic signed [32:0] VEL_MAX = (ONE_S <<< (VEL_WIDTH - 1)) - ONE_S;
    localparam logic signed [32:0] VEL_MIN = -VEL_MAX - ONE_S;

    function automatic logic signed [31:0] sat_32(input logic signed [32:0] x);
        if (x[32] != x[31])
            sat_32 = {x[32], {31{~x[32]}}};
        else
            sat_32 = x[31:0];
    endfunction

    // profile state
    logic signed [31:0]      tv_reg, tv_next;
    logic [TICK_WIDTH-1:0]   accel_left_reg, accel_left_next;
    logic [TICK_WIDTH-1:0]   cruise_left_reg, cruise_left_next;
    logic [TICK_WIDTH-1:0]   decel_left_reg, decel_left_next;
    logic                    done_reg, done_next;

    // stage 1
    stage_ctl_t              s1_ctl_reg;
    logic                    s1_hold_reg;
    logic                    s1_neg_reg;
    logic signed [31:0]      s1_tv_reg;
    logic signed [VEL_WIDTH-1:0] s1_meas_l_reg;
    logic signed [VEL_WIDTH-1:0] s1_meas_r_reg;

    // stage 2
    stage_ctl_t              s2_ctl_reg;
    logic signed [VEL_WIDTH:0] err_l_reg, err_l_next;
    logic signed [VEL_WIDTH:0] err_r_reg, err_r_next;

    logic                    hold;
    logic signed [31:0]      tv_up, tv_dn;
    logic signed [32:0]      tgt_full;
    logic signed [VEL_WIDTH-1:0] tgt;

    assign hold  = (cfg.direction == DIR_HOLD);
    assign tv_up = sat_32(33'(tv_reg) + $signed({17'b0, cfg.accel_per_tick}));
    assign tv_dn = sat_32(33'(tv_reg) - $signed({17'b0, cfg.accel_per_tick}));

    always_comb
    begin
        tv_next          = tv_reg;
        accel_left_next  = accel_left_reg;
        cruise_left_next = cruise_left_reg;
        decel_left_next  = decel_left_reg;
        done_next        = done_reg;
        if (accept)
        begin
            if (start)
            begin
                tv_next          = '0;
                accel_left_next  = TICK_WIDTH'(cfg.accel_ticks);
                cruise_left_next = TICK_WIDTH'(cfg.cruise_ticks);
                decel_left_next  = TICK_WIDTH'(cfg.decel_ticks);
                done_next        = 1'b0;
            end
            else if (!hold)
            begin
                if (accel_left_reg != '0)
                begin
                    tv_next         = tv_up;
                    accel_left_next = accel_left_reg - 1'b1;
                end
                else if (cruise_left_reg != '0)
                begin
                    cruise_left_next = cruise_left_reg - 1'b1;
                end
                else if (decel_left_reg != '0)
                begin
                    tv_next         = tv_dn;
                    decel_left_next = decel_left_reg - 1'b1;
                end
                else
                begin
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tv_reg          <= '0;
            accel_left_reg  <= '0;
            cruise_left_reg <= '0;
            decel_left_reg  <= '0;
            done_reg        <= 1'b0;
            s1_ctl_reg      <= '0;
            s2_ctl_reg      <= '0;
        end
        else
        begin
            tv_reg          <= tv_next;
            accel_left_reg  <= accel_left_next;
            cruise_left_reg <= cruise_left_next;
            decel_left_reg  <= decel_left_next;
            done_reg        <= done_next;
            s1_ctl_reg      <= '{valid: accept, start: start, done: done_next};
            s2_ctl_reg      <= s1_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_hold_reg   <= hold;
            s1_neg_reg    <= cfg.direction[1];
            s1_tv_reg     <= tv_next;
            s1_meas_l_reg <= hold ? enc_center : enc_left;
            s1_meas_r_reg <= hold ? enc_center : enc_right;
        end
        err_l_reg <= err_l_next;
        err_r_reg <= err_r_next;
    end

    // target = direction * velocity, clipped to the velocity width
    always_comb
    begin
        tgt_full = s1_neg_reg ? -33'(s1_tv_reg) : 33'(s1_tv_reg);
        if (s1_hold_reg)
            tgt = '0;
        else if (tgt_full > VEL_MAX)
            tgt = VEL_MAX[VEL_WIDTH-1:0];
        else if (tgt_full < VEL_MIN)
            tgt = VEL_MIN[VEL_WIDTH-1:0];
        else
            tgt = tgt_full[VEL_WIDTH-1:0];
        err_l_next = (VEL_WIDTH+1)'(tgt) - (VEL_WIDTH+1)'(s1_meas_l_reg);
        err_r_next = (VEL_WIDTH+1)'(tgt) - (VEL_WIDTH+1)'(s1_meas_r_reg);
    end

    assign ctl       = s2_ctl_reg;
    assign err_left  = err_l_reg;
    assign err_right = err_r_reg;

endmodule

@@ src/tdpid_pid_loop.sv @@
// ============================================================================
// tdpid_pid_loop
// One PID velocity loop: integrator, products, shift and clip (4 stages).
// ============================================================================
module tdpid_pid_loop #(
    parameter int VEL_WIDTH      = 24,
    parameter int INTEGRAL_WIDTH = 40
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tdpid_pkg::stage_ctl_t         ctl_in,
    input  logic signed [VEL_WIDTH:0]     err_in,
    input  tdpid_pkg::gains_t             gains,
    output tdpid_pkg::stage_ctl_t         ctl_out,
    output logic signed [tdpid_pkg::DRIVE_W-1:0] drive
);
    import tdpid_pkg::*;

    localparam int IW   = INTEGRAL_WIDTH;
    localparam int EW   = VEL_WIDTH + 1;
    localparam int DW   = VEL_WIDTH + 2;
    localparam int SW   = ((IW > EW) ? IW : EW) + 1;
    localparam int HI_W = IW - FRAC_SHIFT + 1;
    localparam int P_W  = EW + CFG_W + 1;
    localparam int D_W  = DW + CFG_W + 1;
    localparam int LO_W = FRAC_SHIFT + CFG_W;
    localparam int HP_W = HI_W + CFG_W + 1;
    localparam int FW   = (((D_W + 8) > (LO_W + 1)) ? (D_W + 8) : (LO_W + 1)) + 2;
    localparam int FH_W = FW - FRAC_SHIFT;
    localparam int TW   = ((HP_W > FH_W) ? HP_W : FH_W) + 1;

    localparam logic signed [SW-1:0] ONE_S   = 1;
    localparam logic signed [SW-1:0] INT_MAX = (ONE_S <<< (IW - 1)) - ONE_S;
    localparam logic signed [SW-1:0] INT_MIN = -INT_MAX - ONE_S;
    localparam logic signed [TW-1:0] DRV_MAX = 32767;
    localparam logic signed [TW-1:0] DRV_MIN = -32768;

    // integrator and derivative history
    logic signed [IW-1:0] integ_reg, integ_next;
    logic signed [EW-1:0] prev_reg, prev_next;
    logic signed [SW-1:0] integ_sum;

    stage_ctl_t           s3_ctl_reg, s4_ctl_reg, s5_ctl_reg, s6_ctl_reg;
    logic signed [EW-1:0] s3_e_reg;
    logic signed [DW-1:0] s3_de_reg, de_next;

    logic signed [P_W-1:0]  p_prod_reg;
    logic signed [D_W-1:0]  d_prod_reg;
    logic [LO_W-1:0]        lo_prod_reg;
    logic signed [HP_W-1:0] hi_prod_reg, s5_hi_prod_reg;
    logic signed [FH_W-1:0] frac_hi_reg;
    logic signed [DRIVE_W-1:0] drive_reg, drive_next;

    logic signed [IW:0]     integ_x;
    logic signed [HI_W-1:0] integ_hi;
    logic signed [FW-1:0]   frac_sum;
    logic signed [TW-1:0]   total;

    assign integ_sum = SW'(integ_reg) + SW'(err_in);
    assign de_next   = DW'(err_in) - DW'(prev_reg);

    always_comb
    begin
        integ_next = integ_reg;
        prev_next  = prev_reg;
        if (ctl_in.valid)
        begin
            if (ctl_in.start)
            begin
                integ_next = '0;
                prev_next  = '0;
            end
            else
            begin
                if (integ_sum > INT_MAX)
                    integ_next = INT_MAX[IW-1:0];
                else if (integ_sum < INT_MIN)
                    integ_next = INT_MIN[IW-1:0];
                else
                    integ_next = integ_sum[IW-1:0];
                prev_next = err_in;
            end
        end
    end

    // integrator split: signed high part times gain, 24-bit fraction times gain
    assign integ_x  = (IW+1)'(integ_reg);
    assign integ_hi = $signed(integ_x[IW:FRAC_SHIFT]);

    assign frac_sum = (FW'(p_prod_reg) <<< 8) + (FW'(d_prod_reg) <<< 8)
                    + $signed({{(FW-LO_W){1'b0}}, lo_prod_reg});
    assign total    = TW'(s5_hi_prod_reg) + TW'(frac_hi_reg);

    always_comb
    begin
        if (s5_ctl_reg.start)
            drive_next = '0;
        else if (total > DRV_MAX)
            drive_next = DRV_MAX[DRIVE_W-1:0];
        else if (total < DRV_MIN)
            drive_next = DRV_MIN[DRIVE_W-1:0];
        else
            drive_next = total[DRIVE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg  <= '0;
            prev_reg   <= '0;
            s3_ctl_reg <= '0;
            s4_ctl_reg <= '0;
            s5_ctl_reg <= '0;
            s6_ctl_reg <= '0;
        end
        else
        begin
            integ_reg  <= integ_next;
            prev_reg   <= prev_next;
            s3_ctl_reg <= ctl_in;
            s4_ctl_reg <= s3_ctl_reg;
            s5_ctl_reg <= s4_ctl_reg;
            s6_ctl_reg <= s5_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_e_reg       <= err_in;
        s3_de_reg      <= de_next;
        // integ_reg already holds this word's integrator value here
        p_prod_reg     <= $signed({1'b0, gains.gain_p}) * s3_e_reg;
        d_prod_reg     <= $signed({1'b0, gains.gain_d}) * s3_de_reg;
        lo_prod_reg    <= integ_reg[FRAC_SHIFT-1:0] * gains.gain_i;
        hi_prod_reg    <= integ_hi * $signed({1'b0, gains.gain_i});
        frac_hi_reg    <= frac_sum[FW-1:FRAC_SHIFT];
        s5_hi_prod_reg <= hi_prod_reg;
        drive_reg      <= drive_next;
    end

    assign ctl_out = s6_ctl_reg;
    assign drive   = drive_reg;

endmodule

@@ src/tdpid_out_fifo.sv @@
// ============================================================================
// tdpid_out_fifo
// Result word queue between the pipeline and the drive channel.
// ============================================================================
module tdpid_out_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  tdpid_pkg::result_t  push_data,
    input  logic                pop,
    output logic                not_empty,
    output tdpid_pkg::result_t  head
);
    import tdpid_pkg::*;

    result_t               mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_reg + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];

endmodule

@@ src/trapezoid_profile_dual_pid.sv @@
// ============================================================================
// trapezoid_profile_dual_pid
// Trapezoid velocity profile driving left and right wheel PID loops.
// ============================================================================
// One tick word in gives one drive word out, in order. A new word is taken
// every cycle while tick ready is high. The result shows on the drive
// channel after six pipeline stages, the first loaded at the edge that takes
// its tick word, then the output queue. The one-per-cycle figure is set by
// the two recurrences whose next value is formed combinationally from their
// own registers: the profile counters with the velocity accumulator, and
// each wheel's integrator. An 8-word output queue absorbs stalls on the
// drive side; tick ready drops only when 8 words are outstanding. Write
// configuration only while no words are outstanding. Start words reset the
// profile and both loops and return zero drive with motion_done low.
// ============================================================================
module trapezoid_profile_dual_pid #(
    parameter int VEL_WIDTH      = 24,
    parameter int TICK_WIDTH     = 16,
    parameter int INTEGRAL_WIDTH = 40
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [tdpid_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tdpid_pkg::CFG_W-1:0]       cfg_data,
    tdpid_tick_if.sink                        tick,
    tdpid_drive_if.source                     drive
);
    import tdpid_pkg::*;

    // configuration registers
    logic [CFG_W-1:0] accel_per_tick_reg, accel_ticks_reg, cruise_ticks_reg;
    logic [CFG_W-1:0] decel_ticks_reg, gain_p_reg, gain_i_reg, gain_d_reg;
    logic [1:0]       direction_reg;

    profile_cfg_t prof_cfg;
    gains_t       gains;

    // words accepted but not yet delivered; bounds the queue fill
    logic [FIFO_CNT_W-1:0] pending_reg, pending_next;
    logic                  tick_acc, drive_acc;

    stage_ctl_t                  prof_ctl, left_ctl, right_ctl;
    logic signed [VEL_WIDTH:0]   err_left, err_right;
    logic signed [DRIVE_W-1:0]   drive_l, drive_r;
    result_t                     result, head;
    logic                        not_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_per_tick_reg <= '0;
            accel_ticks_reg    <= '0;
            cruise_ticks_reg   <= '0;
            decel_ticks_reg    <= '0;
            direction_reg      <= DIR_HOLD;
            gain_p_reg         <= GAIN_P_RESET;
            gain_i_reg         <= GAIN_I_RESET;
            gain_d_reg         <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ACCEL_PER_TICK: accel_per_tick_reg <= cfg_data;
                CFG_ACCEL_TICKS:    accel_ticks_reg    <= cfg_data;
                CFG_CRUISE_TICKS:   cruise_ticks_reg   <= cfg_data;
                CFG_DECEL_TICKS:    decel_ticks_reg    <= cfg_data;
                CFG_DIRECTION:      direction_reg      <= cfg_data[1:0];
                CFG_GAIN_P:         gain_p_reg         <= cfg_data;
                CFG_GAIN_I:         gain_i_reg         <= cfg_data;
                CFG_GAIN_D:         gain_d_reg         <= cfg_data;
                default:            ;
            endcase
        end
    end

    assign prof_cfg = '{accel_per_tick: accel_per_tick_reg,
                        accel_ticks:    accel_ticks_reg,
                        cruise_ticks:   cruise_ticks_reg,
                        decel_ticks:    decel_ticks_reg,
                        direction:      direction_reg};
    assign gains    = '{gain_p: gain_p_reg, gain_i: gain_i_reg, gain_d: gain_d_reg};

    // handshake and credit count
    assign tick.ready   = (pending_reg != FIFO_CNT_W'(FIFO_DEPTH));
    assign tick_acc     = tick.valid && tick.ready;
    assign drive_acc    = drive.valid && drive.ready;
    assign pending_next = pending_reg + FIFO_CNT_W'(tick_acc) - FIFO_CNT_W'(drive_acc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_next;
    end

    // stages 1-2: profile, target, error
    tdpid_profile #(
        .VEL_WIDTH  (VEL_WIDTH),
        .TICK_WIDTH (TICK_WIDTH)
    ) u_profile (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (tick_acc),
        .start      (tick.kind),
        .enc_left   (tick.enc_left),
        .enc_right  (tick.enc_right),
        .enc_center (tick.enc_center),
        .cfg        (prof_cfg),
        .ctl        (prof_ctl),
        .err_left   (err_left),
        .err_right  (err_right)
    );

    // stages 3-6: one loop per wheel, run in lockstep
    tdpid_pid_loop #(
        .VEL_WIDTH      (VEL_WIDTH),
        .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
    ) u_pid_left (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (prof_ctl),
        .err_in  (err_left),
        .gains   (gains),
        .ctl_out (left_ctl),
        .drive   (drive_l)
    );

    tdpid_pid_loop #(
        .VEL_WIDTH      (VEL_WIDTH),
        .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
    ) u_pid_right (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (prof_ctl),
        .err_in  (err_right),
        .gains   (gains),
        .ctl_out (right_ctl),
        .drive   (drive_r)
    );

    // right control mirrors left; only the done flag from it is carried
    assign result = '{drive_left:  drive_l,
                      drive_right: drive_r,
                      motion_done: left_ctl.done & right_ctl.done};

    tdpid_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (left_ctl.valid),
        .push_data (result),
        .pop       (drive_acc),
        .not_empty (not_empty),
        .head      (head)
    );

    assign drive.valid       = not_empty;
    assign drive.drive_left  = head.drive_left;
    assign drive.drive_right = head.drive_right;
    assign drive.motion_done = head.motion_done;

endmodule

@@ src/tdpid_checker.sv @@
// ============================================================================
// tdpid_checker
// Port-level checks on the tick and drive channels.
// ============================================================================
module tdpid_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        tick_valid,
    input logic        tick_ready,
    input logic        drive_valid,
    input logic        drive_ready,
    input logic [15:0] drive_left,
    input logic [15:0] drive_right,
    input logic        motion_done
);
    logic [7:0] outstanding_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            outstanding_reg <= '0;
        else
            outstanding_reg <= outstanding_reg + 8'(tick_valid && tick_ready)
                             - 8'(drive_valid && drive_ready);
    end

    // a drive word never appears without a tick word behind it
    a_no_invented_word: assert property (@(posedge clk) disable iff (!rst_n)
        drive_valid |-> outstanding_reg != 8'd0)
        else $error("drive word with no outstanding tick word");

    // back-pressure on ticks only while words are still owed
    a_stall_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !tick_ready |-> outstanding_reg != 8'd0)
        else $error("tick channel stalled with nothing outstanding");

    a_drive_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        drive_valid && !drive_ready |=> drive_valid)
        else $error("drive valid dropped while stalled");

    a_drive_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        drive_valid && !drive_ready |=>
            $stable(drive_left) && $stable(drive_right) && $stable(motion_done))
        else $error("drive word changed while stalled");

endmodule

bind trapezoid_profile_dual_pid tdpid_checker u_tdpid_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .tick_valid  (tick.valid),
    .tick_ready  (tick.ready),
    .drive_valid (drive.valid),
    .drive_ready (drive.ready),
    .drive_left  (drive.drive_left),
    .drive_right (drive.drive_right),
    .motion_done (drive.motion_done)
);

@@ tb/sv/trapezoid_profile_dual_pid_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// trapezoid_profile_dual_pid_tb
// Self-checking bench for the trapezoid profile / dual PID block. Tick and
// start words go in over the tick channel with random gaps. An in-bench
// model of the profile and both PID loops predicts every drive word, and
// each word taken off the drive channel is compared field by field with the
// oldest prediction. Directed phases cover hold mode, every profile phase,
// the reverse direction codes and the saturation rails. Random motion
// sequences with random configuration follow.
// ============================================================================
module trapezoid_profile_dual_pid_tb;
    import tdpid_pkg::*;

    localparam int VEL_W        = 24;
    localparam int TICK_W       = 16;
    localparam int INTEG_W      = 40;
    localparam int LATENCY      = 6;          // tick taken -> drive word shown
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_WORDS = 600;
    // enough ticks at full step to carry the velocity past the 24-bit
    // target range
    localparam int RAIL_TICKS   = 150;

    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_START = 1'b1;

    localparam logic [1:0] DIR_FWD     = 2'b01;
    localparam logic [1:0] DIR_REV     = 2'b11;
    localparam logic [1:0] DIR_REV_ALT = 2'b10;   // -2, decoded as reverse

    localparam logic signed [VEL_W-1:0] ENC_MAX = 24'sh7FFFFF;
    localparam logic signed [VEL_W-1:0] ENC_MIN = 24'sh800000;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    tdpid_tick_if #(.VEL_WIDTH(VEL_W)) tick_ch ();
    tdpid_drive_if                     drive_ch ();

    trapezoid_profile_dual_pid #(
        .VEL_WIDTH     (VEL_W),
        .TICK_WIDTH    (TICK_W),
        .INTEGRAL_WIDTH(INTEG_W)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .tick     (tick_ch),
        .drive    (drive_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 0;
    end

    // ------------------------------------------------------------------------
    // Model of the block: configuration copy and profile / loop state
    // ------------------------------------------------------------------------
    logic [CFG_W-1:0]  m_step     = '0;
    logic [CFG_W-1:0]  m_accel_n  = '0;
    logic [CFG_W-1:0]  m_cruise_n = '0;
    logic [CFG_W-1:0]  m_decel_n  = '0;
    logic [1:0]        m_dir      = DIR_HOLD;
    logic [CFG_W-1:0]  m_gp       = GAIN_P_RESET;
    logic [CFG_W-1:0]  m_gi       = GAIN_I_RESET;
    logic [CFG_W-1:0]  m_gd       = '0;

    longint            m_vel = 0;                 // Q.8, held to 32-bit signed
    logic [TICK_W-1:0] m_accel_left  = '0;
    logic [TICK_W-1:0] m_cruise_left = '0;
    logic [TICK_W-1:0] m_decel_left  = '0;
    longint            m_integ[2]    = '{0, 0};   // [0] left, [1] right
    longint            m_last_err[2] = '{0, 0};
    logic              m_done = 1'b0;

    result_t           drive_expect_q[$];
    result_t           want_word;
    int                mismatches  = 0;
    int                words_sent  = 0;
    int                cycle_count = 0;
    int                sink_hold   = 0;
    bit                idle_en     = 1'b1;

    function automatic longint clamp_signed(input longint x, input int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (x > hi)
            return hi;
        if (x < lo)
            return lo;
        return x;
    endfunction

    // One wheel loop. The full Q.24 sum fits in 64 bits, so the floor is
    // just an arithmetic shift.
    function automatic logic signed [DRIVE_W-1:0] pid_wheel(input int wh, input longint err);
        longint de;
        longint acc;
        m_integ[wh] = clamp_signed(m_integ[wh] + err, INTEG_W);
        de = err - m_last_err[wh];
        m_last_err[wh] = err;
        acc = longint'(m_gp) * err * 256 + longint'(m_gi) * m_integ[wh]
            + longint'(m_gd) * de * 256;
        return DRIVE_W'(clamp_signed(acc >>> FRAC_SHIFT, DRIVE_W));
    endfunction

    function automatic result_t predict_drive(input logic kind,
                                              input logic signed [VEL_W-1:0] el,
                                              input logic signed [VEL_W-1:0] er,
                                              input logic signed [VEL_W-1:0] ec);
        result_t r;
        longint  tgt;
        longint  ml;
        longint  mr;
        r = '0;
        if (kind == KIND_START)
        begin
            m_accel_left  = m_accel_n;
            m_cruise_left = m_cruise_n;
            m_decel_left  = m_decel_n;
            m_vel         = 0;
            m_integ       = '{0, 0};
            m_last_err    = '{0, 0};
            m_done        = 1'b0;
        end
        else
        begin
            if (m_dir == DIR_HOLD)
            begin
                // profile frozen, both loops regulate the body speed to zero
                tgt = 0;
                ml  = ec;
                mr  = ec;
            end
            else
            begin
                if (m_accel_left != 0)
                begin
                    m_vel = clamp_signed(m_vel + longint'(m_step), 32);
                    m_accel_left--;
                end
                else if (m_cruise_left != 0)
                    m_cruise_left--;
                else if (m_decel_left != 0)
                begin
                    m_vel = clamp_signed(m_vel - longint'(m_step), 32);
                    m_decel_left--;
                end
                else
                    m_done = 1'b1;
                ml  = el;
                mr  = er;
                tgt = clamp_signed((m_dir == DIR_FWD) ? m_vel : -m_vel, VEL_W);
            end
            r.drive_left  = pid_wheel(0, tgt - ml);
            r.drive_right = pid_wheel(1, tgt - mr);
        end
        r.motion_done = m_done;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Drive channel: random back-pressure and the result check
    // ------------------------------------------------------------------------
    // After each drive word, a random back-off (sink_hold) may hold ready low; none while idle_en is clear.
    initial
    begin
        drive_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (sink_hold > 0)
            begin
                drive_ch.ready <= 1'b0;
                sink_hold--;
            end
            else
                drive_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && drive_ch.valid && drive_ch.ready)
        begin
            sink_hold = idle_en ? $urandom_range(0, 10) : 0;
            if (drive_expect_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected drive word: L=%0d R=%0d done=%0b",
                             drive_ch.drive_left, drive_ch.drive_right,
                             drive_ch.motion_done);
            end
            else
            begin
                want_word = drive_expect_q.pop_front();
                if (drive_ch.drive_left  !== want_word.drive_left  ||
                    drive_ch.drive_right !== want_word.drive_right ||
                    drive_ch.motion_done !== want_word.motion_done)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("drive mismatch: expected L=%0d R=%0d done=%0b, got L=%0d R=%0d done=%0b",
                                 want_word.drive_left, want_word.drive_right,
                                 want_word.motion_done, drive_ch.drive_left,
                                 drive_ch.drive_right, drive_ch.motion_done);
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers. All of them are entered and left at a falling edge.
    // ------------------------------------------------------------------------
    task automatic send_word(input logic kind,
                             input logic signed [VEL_W-1:0] el,
                             input logic signed [VEL_W-1:0] er,
                             input logic signed [VEL_W-1:0] ec);
        int gap;
        gap = idle_en ? $urandom_range(0, 10) : 0;
        if (gap > 0)
        begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        tick_ch.valid      <= 1'b1;
        tick_ch.kind       <= kind;
        tick_ch.enc_left   <= el;
        tick_ch.enc_right  <= er;
        tick_ch.enc_center <= ec;
        @(posedge clk);
        while (!tick_ch.ready)
            @(posedge clk);
        drive_expect_q.push_back(predict_drive(kind, el, er, ec));
        words_sent++;
        @(negedge clk);
    endtask

    // Stop sending and wait until every predicted word has come back.
    task automatic drain_words();
        tick_ch.valid <= 1'b0;
        while (drive_expect_q.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 1) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            CFG_ACCEL_PER_TICK: m_step     = val;
            CFG_ACCEL_TICKS:    m_accel_n  = val;
            CFG_CRUISE_TICKS:   m_cruise_n = val;
            CFG_DECEL_TICKS:    m_decel_n  = val;
            CFG_DIRECTION:      m_dir      = val[1:0];
            CFG_GAIN_P:         m_gp       = val;
            CFG_GAIN_I:         m_gi       = val;
            CFG_GAIN_D:         m_gd       = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Write every register. Upper bits of the direction word are junk on
    // purpose; only the low two bits count.
    task automatic program_all(input logic [CFG_W-1:0] step, input logic [CFG_W-1:0] na,
                               input logic [CFG_W-1:0] nc, input logic [CFG_W-1:0] nd,
                               input logic [1:0] dir, input logic [CFG_W-1:0] gp,
                               input logic [CFG_W-1:0] gi, input logic [CFG_W-1:0] gd);
        write_reg(CFG_ACCEL_PER_TICK, step);
        write_reg(CFG_ACCEL_TICKS, na);
        write_reg(CFG_CRUISE_TICKS, nc);
        write_reg(CFG_DECEL_TICKS, nd);
        write_reg(CFG_DIRECTION, {14'($urandom()), dir});
        write_reg(CFG_GAIN_P, gp);
        write_reg(CFG_GAIN_I, gi);
        write_reg(CFG_GAIN_D, gd);
    endtask

    // Random encoder reading; a larger shift gives a smaller magnitude,
    // either sign.
    function automatic logic signed [VEL_W-1:0] rand_enc(input int shift);
        logic signed [VEL_W-1:0] v;
        v = VEL_W'($urandom());
        return v >>> shift;
    endfunction

    function automatic logic [CFG_W-1:0] rand_wide();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return CFG_W'($urandom_range(0, 1023));
            default: return CFG_W'($urandom());
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] rand_count();
        case ($urandom_range(0, 15))
            0:       return '1;
            1:       return '0;
            default: return CFG_W'($urandom_range(0, 15));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Straight out of reset the block is in hold mode with default gains:
    // both loops track the centre encoder toward zero. A start word in hold
    // mode still returns a zero word.
    task automatic test_hold_after_reset();
        send_word(KIND_TICK, rand_enc(0), rand_enc(0), ENC_MAX);
        send_word(KIND_TICK, rand_enc(0), rand_enc(0), ENC_MIN);
        send_word(KIND_TICK, ENC_MAX, ENC_MIN, 24'sd0);
        send_word(KIND_START, rand_enc(0), rand_enc(0), rand_enc(0));
        send_word(KIND_TICK, rand_enc(0), rand_enc(0), -24'sd256);
        drain_words();
    endtask

    // Walk one short trapezoid through accelerate, cruise, decelerate and
    // done, then freeze it in hold mode and resume; a start clears done.
    task automatic test_profile_phases();
        program_all(16'd512, 16'd3, 16'd2, 16'd3, DIR_FWD, '1, '1, '1);
        send_word(KIND_START, 24'sd0, 24'sd0, 24'sd0);
        for (int i = 0; i < 10; i++)
        begin
            if (i % 2 == 0)
                send_word(KIND_TICK, ENC_MAX, ENC_MIN, rand_enc(0));
            else
                send_word(KIND_TICK, ENC_MIN, ENC_MAX, rand_enc(0));
        end
        drain_words();
        write_reg(CFG_DIRECTION, {14'd0, DIR_HOLD});
        write_reg(CFG_GAIN_P, '0);
        write_reg(CFG_GAIN_I, '0);
        write_reg(CFG_GAIN_D, '0);
        send_word(KIND_TICK, rand_enc(0), rand_enc(0), rand_enc(0));
        send_word(KIND_TICK, rand_enc(0), rand_enc(0), rand_enc(0));
        drain_words();
        write_reg(CFG_DIRECTION, {14'd0, DIR_FWD});
        send_word(KIND_TICK, rand_enc(4), rand_enc(4), rand_enc(4));
        send_word(KIND_START, rand_enc(0), rand_enc(0), rand_enc(0));
        drain_words();
    endtask

    // Both reverse codes, with a cruise phase of zero length.
    task automatic test_reverse_codes();
        program_all('1, 16'd1, 16'd0, 16'd0, DIR_REV, 16'd1024, 16'd655, 16'd256);
        send_word(KIND_START, 24'sd0, 24'sd0, 24'sd0);
        send_word(KIND_TICK, rand_enc(8), rand_enc(8), rand_enc(0));
        send_word(KIND_TICK, rand_enc(8), rand_enc(8), rand_enc(0));
        drain_words();
        write_reg(CFG_DIRECTION, {14'd0, DIR_REV_ALT});
        send_word(KIND_TICK, rand_enc(8), rand_enc(8), rand_enc(0));
        send_word(KIND_TICK, rand_enc(8), rand_enc(8), rand_enc(0));
        drain_words();
    endtask

    // Back-to-back runs at full step: the velocity grows past the 24-bit
    // range, so reverse times a positive velocity pins the target to the
    // low rail and reverse times a negative velocity pins it to the high
    // rail. The large errors drive both outputs into their 16-bit limits.
    task automatic test_velocity_rails();
        idle_en = 1'b0;
        program_all('1, '1, 16'd0, 16'd0, DIR_REV, 16'd1, '1, 16'd1);
        send_word(KIND_START, 24'sd0, 24'sd0, 24'sd0);
        for (int i = 0; i < RAIL_TICKS; i++)
            send_word(KIND_TICK, ENC_MAX, rand_enc($urandom_range(0, 23)), rand_enc(0));
        drain_words();
        program_all('1, 16'd0, 16'd0, '1, DIR_REV_ALT, 16'd3, '1, 16'd0);
        send_word(KIND_START, 24'sd0, 24'sd0, 24'sd0);
        for (int i = 0; i < RAIL_TICKS; i++)
            send_word(KIND_TICK, ENC_MIN, rand_enc($urandom_range(0, 23)), rand_enc(0));
        drain_words();
        idle_en = 1'b1;
    endtask

    // Random motion sequences: fresh configuration, usually a start word,
    // then enough ticks to run the profile out most of the time. Encoder
    // magnitude is set per sequence; a few stray start words land mid-run.
    task automatic test_random_motion();
        int               stop_at;
        int               n;
        int               shift;
        logic [CFG_W-1:0] na;
        logic [CFG_W-1:0] nc;
        logic [CFG_W-1:0] nd;
        logic [1:0]       dir;
        stop_at = words_sent + RANDOM_WORDS;
        while (words_sent < stop_at)
        begin
            na = rand_count();
            nc = rand_count();
            nd = rand_count();
            case ($urandom_range(0, 7))
                0:       dir = DIR_HOLD;
                5, 6:    dir = DIR_REV;
                7:       dir = DIR_REV_ALT;
                default: dir = DIR_FWD;
            endcase
            idle_en = ($urandom_range(0, 4) != 0);
            program_all(rand_wide(), na, nc, nd, dir, rand_wide(), rand_wide(), rand_wide());
            shift = $urandom_range(0, 22);
            if ($urandom_range(0, 7) != 0)
                send_word(KIND_START, rand_enc(0), rand_enc(0), rand_enc(0));
            if (na < 16 && nc < 16 && nd < 16)
                n = na + nc + nd + $urandom_range(0, 8);
            else
                n = $urandom_range(5, 60);
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 39) == 0)
                    send_word(KIND_START, rand_enc(0), rand_enc(0), rand_enc(0));
                else
                    send_word(KIND_TICK, rand_enc(shift), rand_enc(shift), rand_enc(shift));
            end
            drain_words();
        end
        idle_en = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Run
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        tick_ch.valid      = 1'b0;
        tick_ch.kind       = KIND_TICK;
        tick_ch.enc_left   = '0;
        tick_ch.enc_right  = '0;
        tick_ch.enc_center = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_hold_after_reset();
        test_profile_phases();
        test_reverse_codes();
        test_velocity_rails();
        test_random_motion();

        // drain_words already waited out the pipeline; a little extra
        // catches any stray word
        repeat (2 * LATENCY) @(negedge clk);
        if (mismatches == 0 && drive_expect_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ files.f @@
src/tdpid_pkg.sv
src/tdpid_if.sv
src/tdpid_profile.sv
src/tdpid_pid_loop.sv
src/tdpid_out_fifo.sv
src/trapezoid_profile_dual_pid.sv
src/tdpid_checker.sv
tb/sv/trapezoid_profile_dual_pid_tb.sv
